// File: rtl/scg_pkg.sv
// shared types, constants and codes for the stream consumer gate
package scg_pkg;

    // width of the in-flight chunk counter
    localparam int COUNT_WIDTH   = 16;
    // fixed widths of the register and result fields
    localparam int LIMIT_WIDTH   = 16;
    localparam int BACKLOG_WIDTH = 16;
    // width used to compare the count against the limit
    localparam int CMP_WIDTH     = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(64);

    // event kinds
    typedef enum logic [1:0] {
        MODE_VIDEO = 2'd0,
        MODE_AUDIO = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // start-up and flow-control states
    typedef enum logic [2:0] {
        ST_WAIT_META = 3'd0,
        ST_WAIT_VHDR = 3'd1,
        ST_WAIT_AHDR = 3'd2,
        ST_RUN       = 3'd3,
        ST_VSLOW     = 3'd4,
        ST_ASLOW     = 3'd5
    } t_gate_state;

    // per-chunk actions
    typedef enum logic [2:0] {
        ACT_DROP          = 3'd0,
        ACT_FWD           = 3'd1,
        ACT_META_VHDR_KEY = 3'd2,
        ACT_VHDR_KEY      = 3'd3,
        ACT_META_AUDIO    = 3'd4,
        ACT_AHDR_AUDIO    = 3'd5
    } t_action;

    // one input item
    typedef struct packed {
        t_mode mode;
        logic  is_keyframe;
        logic  is_continuation;
        logic  metadata_ready;
        logic  video_header_ready;
        logic  audio_header_ready;
    } t_item;

    // gate state held between items
    typedef struct packed {
        t_gate_state           gate_state;
        logic [COUNT_WIDTH-1:0] in_flight;
    } t_gate;

    // decision for one item
    typedef struct packed {
        t_action action;
        logic    with_audio_header;
        t_gate   gate;
    } t_decision;

endpackage

// File: rtl/scg_in_if.sv
// input item channel of the stream consumer gate
interface scg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       is_keyframe;
    logic       is_continuation;
    logic       metadata_ready;
    logic       video_header_ready;
    logic       audio_header_ready;

    modport source (
        output valid, mode, is_keyframe, is_continuation,
               metadata_ready, video_header_ready, audio_header_ready,
        input  ready
    );
    modport sink (
        input  valid, mode, is_keyframe, is_continuation,
               metadata_ready, video_header_ready, audio_header_ready,
        output ready
    );
endinterface

// File: rtl/scg_out_if.sv
// result item channel of the stream consumer gate
interface scg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        with_audio_header;
    logic [2:0]  state_now;
    logic [15:0] backlog;

    modport source (
        output valid, action, with_audio_header, state_now, backlog,
        input  ready
    );
    modport sink (
        input  valid, action, with_audio_header, state_now, backlog,
        output ready
    );
endinterface

// File: rtl/scg_cfg_if.sv
// configuration write channel carrying the backlog limit
interface scg_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/scg_decide.sv
// next-state, counter and action logic for one item
module scg_decide (
    input  scg_pkg::t_item                    i_item,
    input  scg_pkg::t_gate                    i_gate,
    input  logic [scg_pkg::LIMIT_WIDTH-1:0]   i_limit,
    output scg_pkg::t_decision                o_dec
);
    import scg_pkg::*;

    logic [CMP_WIDTH-1:0]   cmp_count;
    logic [CMP_WIDTH-1:0]   cmp_limit;
    logic                   over;
    logic                   under;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_dec;

    // count compare against the limit
    assign cmp_count = CMP_WIDTH'(i_gate.in_flight);
    assign cmp_limit = CMP_WIDTH'(i_limit);
    assign over      = cmp_count > cmp_limit;
    assign under     = cmp_count < cmp_limit;

    // saturating increment and decrement
    assign count_inc = (i_gate.in_flight == {COUNT_WIDTH{1'b1}}) ?
                       i_gate.in_flight : i_gate.in_flight + COUNT_WIDTH'(1);
    assign count_dec = (i_gate.in_flight == '0) ?
                       i_gate.in_flight : i_gate.in_flight - COUNT_WIDTH'(1);

    // decision per event kind and state
    always_comb begin
        o_dec.action            = ACT_DROP;
        o_dec.with_audio_header = 1'b0;
        o_dec.gate              = i_gate;
        case (i_item.mode)
            MODE_VIDEO: begin
                case (i_gate.gate_state)
                    ST_RUN, ST_WAIT_AHDR: begin
                        if (!i_item.is_continuation && over) begin
                            o_dec.gate.gate_state = ST_VSLOW;
                        end else begin
                            o_dec.action          = ACT_FWD;
                            o_dec.gate.in_flight  = count_inc;
                        end
                    end
                    ST_WAIT_META: begin
                        if (i_item.is_keyframe && i_item.metadata_ready &&
                            i_item.video_header_ready) begin
                            o_dec.action          = ACT_META_VHDR_KEY;
                            o_dec.gate.gate_state = ST_WAIT_AHDR;
                        end
                    end
                    ST_WAIT_VHDR: begin
                        if (i_item.is_keyframe && i_item.video_header_ready) begin
                            o_dec.action          = ACT_VHDR_KEY;
                            o_dec.gate.gate_state = ST_RUN;
                        end
                    end
                    ST_VSLOW: begin
                        if (under && i_item.is_keyframe) begin
                            o_dec.action          = ACT_FWD;
                            o_dec.gate.gate_state = ST_RUN;
                            o_dec.gate.in_flight  = count_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_AUDIO: begin
                case (i_gate.gate_state)
                    ST_RUN, ST_WAIT_VHDR: begin
                        if (!i_item.is_continuation && over) begin
                            o_dec.gate.gate_state = (i_gate.gate_state == ST_WAIT_VHDR) ?
                                                    ST_ASLOW : ST_VSLOW;
                        end else begin
                            o_dec.action          = ACT_FWD;
                            o_dec.gate.in_flight  = count_inc;
                        end
                    end
                    ST_WAIT_META: begin
                        if (i_item.metadata_ready && !i_item.video_header_ready &&
                            !i_item.is_continuation) begin
                            o_dec.action            = ACT_META_AUDIO;
                            o_dec.with_audio_header = i_item.audio_header_ready;
                            o_dec.gate.gate_state   = ST_WAIT_VHDR;
                        end
                    end
                    ST_WAIT_AHDR: begin
                        // continuation flag not checked here
                        if (i_item.audio_header_ready) begin
                            o_dec.action          = ACT_AHDR_AUDIO;
                            o_dec.gate.gate_state = ST_RUN;
                        end
                    end
                    ST_ASLOW: begin
                        if (under && !i_item.is_continuation) begin
                            o_dec.action          = ACT_FWD;
                            o_dec.gate.gate_state = ST_RUN;
                            o_dec.gate.in_flight  = count_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_DONE: begin
                o_dec.gate.in_flight = count_dec;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/stream_consumer_gate_top.sv
// top level of the stream consumer gate: input register, decision, result register
// Per-viewer gate for a live media stream.
// Channels: i_in takes one event item (video chunk, audio chunk or write
// completed); o_out returns one result item per event with the chosen
// action, the audio header flag, the gate state and the in-flight count
// after the event; i_cfg writes the backlog limit and is always ready.
// Path: an accepted item waits in the input register, and its result
// is then held in the result register.
// Throughput: one item per cycle while o_out.ready stays high; the
// gate state and in-flight counter update as an item moves from the
// input register to the result register.
// Reset: synchronous, active low; the gate waits for metadata, the count
// is zero, the limit is 64 and both registers are empty.
// Stall: while o_out.ready is low the result holds, the input register
// still fills once, and i_in.ready then drops until the result is taken.
// Write the limit only while no item is in flight through the block.
module stream_consumer_gate_top (
    input  logic i_clk,
    input  logic i_rst_n,
    scg_in_if.sink    i_in,
    scg_out_if.source o_out,
    scg_cfg_if.sink   i_cfg
);
    import scg_pkg::*;

    logic                   r_in_vld;
    t_item                  r_item;
    logic                   r_out_vld;
    t_decision              r_res;
    t_gate                  r_gate;
    logic [LIMIT_WIDTH-1:0] r_limit;

    t_item                  n_item;
    t_decision              n_res;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // handshake control
    assign out_free = !r_out_vld || o_out.ready;
    assign advance  = r_in_vld && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_vld || out_free;
    assign i_cfg.ready = 1'b1;

    // incoming item payload
    always_comb begin
        n_item.mode               = t_mode'(i_in.mode);
        n_item.is_keyframe        = i_in.is_keyframe;
        n_item.is_continuation    = i_in.is_continuation;
        n_item.metadata_ready     = i_in.metadata_ready;
        n_item.video_header_ready = i_in.video_header_ready;
        n_item.audio_header_ready = i_in.audio_header_ready;
    end

    // decision logic
    scg_decide u_decide (
        .i_item  (r_item),
        .i_gate  (r_gate),
        .i_limit (r_limit),
        .o_dec   (n_res)
    );

    // control registers and gate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld          <= 1'b0;
            r_out_vld         <= 1'b0;
            r_gate.gate_state <= ST_WAIT_META;
            r_gate.in_flight  <= '0;
            r_limit           <= LIMIT_RESET;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_gate    <= n_res.gate;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // result item
    assign o_out.valid             = r_out_vld;
    assign o_out.action            = r_res.action;
    assign o_out.with_audio_header = r_res.with_audio_header;
    assign o_out.state_now         = r_res.gate.gate_state;
    assign o_out.backlog           = BACKLOG_WIDTH'(r_res.gate.in_flight);

`ifndef SYNTHESIS
    // audio header flag only comes with the metadata plus first audio action
    a_ahdr_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.with_audio_header |-> o_out.action == ACT_META_AUDIO)
        else $error("audio header flag without metadata audio action");

    // a forwarded chunk leaves a nonzero count
    a_fwd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == ACT_FWD |-> o_out.backlog != '0)
        else $error("forward reported with zero backlog");

    // start sequences land in the expected state
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.action == ACT_VHDR_KEY || o_out.action == ACT_AHDR_AUDIO)
        |-> o_out.state_now == ST_RUN)
        else $error("start sequence without entering run state");

    // gate state only changes when an item passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_gate))
        else $error("gate state changed without an item");
`endif

endmodule

// File: sim/tb.sv
// testbench for the stream consumer gate: directed start-up table, then random events checked
module tb;
    import scg_pkg::*;

    localparam int TOTAL_TIME  = 20 * 500000;
    localparam int HOLD_AFTER  = 200;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int DIR_ROWS    = 39;
    localparam logic [COUNT_WIDTH-1:0] FLIGHT_MAX = '1;

    // kinds of rows in the directed table
    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } t_row_kind;

    // start-up path that a table row belongs to
    typedef enum logic [1:0] {
        START_ANY        = 2'd0,
        START_VIDEO      = 2'd1,
        START_AUDIO      = 2'd2,
        START_AUDIO_SLOW = 2'd3
    } t_start;

    // one result item
    typedef struct packed {
        t_action                  action;
        logic                     with_ah;
        t_gate_state              state;
        logic [BACKLOG_WIDTH-1:0] backlog;
    } t_result;

    // flags are {keyframe, continuation, metadata, video header, audio header}
    typedef struct {
        t_row_kind                kind;
        t_start                   path;
        t_mode                    mode;
        logic [4:0]               flags;
        logic                     typed;
        t_action                  act;
        logic                     with_ah;
        t_gate_state              st;
        logic [BACKLOG_WIDTH-1:0] bl;
        logic [LIMIT_WIDTH-1:0]   limit;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // waiting for metadata: nothing starts the stream
        '{ROW_ITEM,  START_ANY,   MODE_NONE,  5'b11111, 1, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_DONE,  5'b00000, 1, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b00111, 1, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_AUDIO, 5'b00110, 1, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_AUDIO, 5'b01101, 1, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        // video first: keyframe start, then audio header
        '{ROW_ITEM,  START_VIDEO, MODE_VIDEO, 5'b11111, 1, ACT_META_VHDR_KEY, 0,
          ST_WAIT_AHDR, 0, 0},
        '{ROW_ITEM,  START_VIDEO, MODE_VIDEO, 5'b00000, 1, ACT_FWD, 0, ST_WAIT_AHDR, 1, 0},
        '{ROW_ITEM,  START_VIDEO, MODE_AUDIO, 5'b01110, 1, ACT_DROP, 0, ST_WAIT_AHDR, 1, 0},
        '{ROW_LIMIT, START_VIDEO, MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_VIDEO, MODE_VIDEO, 5'b01000, 1, ACT_FWD, 0, ST_WAIT_AHDR, 2, 0},
        '{ROW_ITEM,  START_VIDEO, MODE_AUDIO, 5'b00001, 1, ACT_AHDR_AUDIO, 0, ST_RUN, 2, 0},
        // audio first, then a keyframe with video header
        '{ROW_ITEM,  START_AUDIO, MODE_AUDIO, 5'b00100, 1, ACT_META_AUDIO, 0, ST_WAIT_VHDR, 0, 0},
        '{ROW_ITEM,  START_AUDIO, MODE_AUDIO, 5'b01000, 1, ACT_FWD, 0, ST_WAIT_VHDR, 1, 0},
        '{ROW_ITEM,  START_AUDIO, MODE_VIDEO, 5'b10101, 1, ACT_DROP, 0, ST_WAIT_VHDR, 1, 0},
        '{ROW_LIMIT, START_AUDIO, MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_AUDIO, MODE_VIDEO, 5'b10010, 1, ACT_VHDR_KEY, 0, ST_RUN, 1, 0},
        // audio first, backlog over the limit, audio slow and recovery
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b00101, 1, ACT_META_AUDIO, 1,
          ST_WAIT_VHDR, 0, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b00000, 1, ACT_FWD, 0, ST_WAIT_VHDR, 1, 0},
        '{ROW_LIMIT, START_AUDIO_SLOW, MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b00000, 1, ACT_DROP, 0, ST_ASLOW, 1, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_VIDEO, 5'b10111, 1, ACT_DROP, 0, ST_ASLOW, 1, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b00000, 1, ACT_DROP, 0, ST_ASLOW, 1, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_DONE,  5'b00000, 1, ACT_DROP, 0, ST_ASLOW, 0, 0},
        '{ROW_LIMIT, START_AUDIO_SLOW, MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 2},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b01000, 1, ACT_DROP, 0, ST_ASLOW, 0, 0},
        '{ROW_ITEM,  START_AUDIO_SLOW, MODE_AUDIO, 5'b00000, 1, ACT_FWD, 0, ST_RUN, 1, 0},
        // running: video slow, drain to zero, resume on a keyframe
        '{ROW_LIMIT, START_ANY,   MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 1},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b01000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_AUDIO, 5'b01000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_AUDIO, 5'b00101, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b10000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_DONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_DONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_DONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_DONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_ITEM,  START_ANY,   MODE_VIDEO, 5'b10000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 0},
        '{ROW_LIMIT, START_ANY,   MODE_NONE,  5'b00000, 0, ACT_DROP, 0, ST_WAIT_META, 0, 16'hFFFF}
    };

    logic clk = 1'b0;
    logic rst_n;

    scg_in_if  in_ch ();
    scg_out_if out_ch ();
    scg_cfg_if cfg_ch ();

    stream_consumer_gate_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted gate state, in-flight count and limit
    t_gate_state              gate_st       = ST_WAIT_META;
    logic [COUNT_WIDTH-1:0]   flight_count  = '0;
    logic [LIMIT_WIDTH-1:0]   backlog_limit = LIMIT_RESET;

    t_result awaited_results [$];
    int errors        = 0;
    int items_sent    = 0;
    int results_taken = 0;
    logic burst       = 1'b0;
    logic tx_quiet    = 1'b0;
    logic rx_quiet    = 1'b0;

    always #10 clk = ~clk;

    // a forwarded chunk counts as in flight, saturating at the top
    function automatic t_action take_forward();
        if (flight_count != FLIGHT_MAX) begin
            flight_count = flight_count + 1'b1;
        end
        return ACT_FWD;
    endfunction

    // next gate state and result for one event
    function automatic t_result gate_step(input t_item it);
        t_result res;
        logic over;
        logic under;
        over        = flight_count > backlog_limit;
        under       = flight_count < backlog_limit;
        res.action  = ACT_DROP;
        res.with_ah = 1'b0;
        case (it.mode)
            MODE_VIDEO: begin
                case (gate_st)
                    ST_RUN, ST_WAIT_AHDR: begin
                        if (!it.is_continuation && over) begin
                            gate_st = ST_VSLOW;
                        end else begin
                            res.action = take_forward();
                        end
                    end
                    ST_WAIT_META: begin
                        if (it.is_keyframe && it.metadata_ready && it.video_header_ready) begin
                            res.action = ACT_META_VHDR_KEY;
                            gate_st    = ST_WAIT_AHDR;
                        end
                    end
                    ST_WAIT_VHDR: begin
                        if (it.is_keyframe && it.video_header_ready) begin
                            res.action = ACT_VHDR_KEY;
                            gate_st    = ST_RUN;
                        end
                    end
                    ST_VSLOW: begin
                        if (under && it.is_keyframe) begin
                            gate_st    = ST_RUN;
                            res.action = take_forward();
                        end
                    end
                    default: ;
                endcase
            end
            MODE_AUDIO: begin
                case (gate_st)
                    ST_RUN, ST_WAIT_VHDR: begin
                        if (!it.is_continuation && over) begin
                            gate_st = (gate_st == ST_WAIT_VHDR) ? ST_ASLOW : ST_VSLOW;
                        end else begin
                            res.action = take_forward();
                        end
                    end
                    ST_WAIT_META: begin
                        if (it.metadata_ready && !it.video_header_ready &&
                                !it.is_continuation) begin
                            res.action  = ACT_META_AUDIO;
                            res.with_ah = it.audio_header_ready;
                            gate_st     = ST_WAIT_VHDR;
                        end
                    end
                    ST_WAIT_AHDR: begin
                        if (it.audio_header_ready) begin
                            res.action = ACT_AHDR_AUDIO;
                            gate_st    = ST_RUN;
                        end
                    end
                    ST_ASLOW: begin
                        if (under && !it.is_continuation) begin
                            gate_st    = ST_RUN;
                            res.action = take_forward();
                        end
                    end
                    default: ;
                endcase
            end
            MODE_DONE: begin
                if (flight_count != '0) begin
                    flight_count = flight_count - 1'b1;
                end
            end
            default: ;
        endcase
        res.state   = gate_st;
        res.backlog = BACKLOG_WIDTH'(flight_count);
        return res;
    endfunction

    // random event with a given share of write completions
    function automatic t_item random_item(input int done_pct);
        t_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.mode = MODE_NONE;
        end else if (pick < 4 + done_pct) begin
            it.mode = MODE_DONE;
        end else if (pick % 2 == 0) begin
            it.mode = MODE_VIDEO;
        end else begin
            it.mode = MODE_AUDIO;
        end
        {it.is_keyframe, it.is_continuation, it.metadata_ready,
         it.video_header_ready, it.audio_header_ready} = 5'($urandom_range(0, 31));
        return it;
    endfunction

    // offer one item after a random gap and record its result at acceptance
    task automatic send_item(input t_item it, input logic typed, input t_result typed_res);
        int gap;
        t_result res;
        if (items_sent % 32 == 0) begin
            tx_quiet = ($urandom_range(0, 2) == 0);
        end
        gap = (burst || tx_quiet) ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.mode               = it.mode;
        in_ch.is_keyframe        = it.is_keyframe;
        in_ch.is_continuation    = it.is_continuation;
        in_ch.metadata_ready     = it.metadata_ready;
        in_ch.video_header_ready = it.video_header_ready;
        in_ch.audio_header_ready = it.audio_header_ready;
        in_ch.valid              = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        res = gate_step(it);
        awaited_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // write the limit once every result is back
    task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        backlog_limit = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic run_phase(input logic [LIMIT_WIDTH-1:0] value, input int count,
                             input int done_pct);
        write_limit(value);
        repeat (count) send_item(random_item(done_pct), 1'b0, '0);
    endtask

    // result side: random stalls, one long hold, field checks
    initial begin
        int stall;
        t_result want;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (results_taken % 32 == 0) begin
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            stall = (burst || rx_quiet) ? 0 : $urandom_range(0, 14);
            if (results_taken == HOLD_AFTER) begin
                stall = LONG_HOLD;
            end
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            if (awaited_results.size() == 0) begin
                $error("result item with no item pending: action %0d backlog %0d",
                       out_ch.action, out_ch.backlog);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (out_ch.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, out_ch.action);
                    errors++;
                end
                if (out_ch.with_audio_header !== want.with_ah) begin
                    $error("with_audio_header: expected %0d, got %0d",
                           want.with_ah, out_ch.with_audio_header);
                    errors++;
                end
                if (out_ch.state_now !== want.state) begin
                    $error("state_now: expected %0d, got %0d", want.state, out_ch.state_now);
                    errors++;
                end
                if (out_ch.backlog !== want.backlog) begin
                    $error("backlog: expected %0d, got %0d", want.backlog, out_ch.backlog);
                    errors++;
                end
            end
            results_taken++;
        end
    end

    // stimulus: reset, directed table, random phases, full-rate tail
    initial begin
        t_start chosen;
        t_item it;
        t_result typed_res;
        logic [LIMIT_WIDTH-1:0] lim;
        rst_n                    = 1'b0;
        in_ch.valid              = 1'b0;
        in_ch.mode               = MODE_VIDEO;
        in_ch.is_keyframe        = 1'b0;
        in_ch.is_continuation    = 1'b0;
        in_ch.metadata_ready     = 1'b0;
        in_ch.video_header_ready = 1'b0;
        in_ch.audio_header_ready = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.data              = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // one start-up path per run, picked by the seed
        chosen = t_start'($urandom_range(1, 3));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].path == START_ANY || dir_rows[i].path == chosen) begin
                if (dir_rows[i].kind == ROW_LIMIT) begin
                    write_limit(dir_rows[i].limit);
                end else begin
                    it.mode = dir_rows[i].mode;
                    {it.is_keyframe, it.is_continuation, it.metadata_ready,
                     it.video_header_ready, it.audio_header_ready} = dir_rows[i].flags;
                    typed_res = '{dir_rows[i].act, dir_rows[i].with_ah,
                                  dir_rows[i].st, dir_rows[i].bl};
                    send_item(it, dir_rows[i].typed, typed_res);
                end
            end
        end

        // random phases, mostly small limits so the viewer keeps going slow
        for (int p = 0; p < 10; p++) begin
            if (p == 0) begin
                lim = 16'hFFFF;
            end else if (p == 3) begin
                lim = 16'h0000;
            end else if ($urandom_range(0, 3) == 0) begin
                lim = LIMIT_WIDTH'($urandom_range(0, 65535));
            end else begin
                lim = LIMIT_WIDTH'($urandom_range(0, 12));
            end
            run_phase(lim, 50, $urandom_range(15, 45));
        end

        // both sides at full rate against a small limit
        burst = 1'b1;
        run_phase(16'd3, 40, 30);
        burst = 1'b0;

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TOTAL_TIME);
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/scg_pkg.sv
rtl/scg_in_if.sv
rtl/scg_out_if.sv
rtl/scg_cfg_if.sv
rtl/scg_decide.sv
rtl/stream_consumer_gate_top.sv
sim/tb.sv
